@@ hdl/cia_pkg.sv @@
// Shared types, opcodes and helper functions of the checked integer ALU.
package cia_pkg;

	localparam int DATA_W     = 64;
	localparam int MAX_WIDTH  = 64;
	localparam int WBITS      = 7;
	localparam int DIV_STAGES = DATA_W;
	// Decode register, one divider stage per quotient bit, then the output register.
	localparam int LAST_SIDE  = 1 + DIV_STAGES;
	localparam int LAST_STAGE = LAST_SIDE + 1;

	typedef enum logic [4:0] {
		OP_ADDC  = 5'd0,
		OP_SUBC  = 5'd1,
		OP_MULC  = 5'd2,
		OP_DIVC  = 5'd3,
		OP_REMC  = 5'd4,
		OP_ADDW  = 5'd5,
		OP_SUBW  = 5'd6,
		OP_MULW  = 5'd7,
		OP_AND   = 5'd8,
		OP_OR    = 5'd9,
		OP_XOR   = 5'd10,
		OP_SHL   = 5'd11,
		OP_ASHR  = 5'd12,
		OP_LSHR  = 5'd13,
		OP_NEGC  = 5'd14,
		OP_NEGW  = 5'd15,
		OP_NOT   = 5'd16,
		OP_CASTC = 5'd17,
		OP_TRUNC = 5'd18
	} opcode_t;

	typedef struct packed {
		logic [4:0]        operation;
		logic [DATA_W-1:0] lhs;
		logic [DATA_W-1:0] rhs;
		logic [WBITS-1:0]  value_bits;
		logic              value_signed;
		logic [WBITS-1:0]  count_bits;
		logic              count_signed;
		logic [WBITS-1:0]  cast_bits;
		logic              target_signed;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic              trap;
	} rsp_t;

	typedef struct packed {
		logic [4:0]        op;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] m;
		logic [DATA_W-1:0] ma;
		logic [DATA_W-1:0] mb;
		logic              na;
		logic              nb;
		logic              vs;
		logic [WBITS-1:0]  w;
		logic [DATA_W-1:0] cnt;
		logic              cnt_neg;
		logic [WBITS-1:0]  tw;
		logic              ts;
	} dec_t;

	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic              trap;
		logic              is_div;
		logic              div_trap;
		logic              qneg;
		logic              rneg;
		logic              rem_op;
		logic [DATA_W-1:0] m;
	} side_t;

	typedef struct packed {
		logic [DATA_W-1:0] ll;
		logic [DATA_W-1:0] lh;
		logic [DATA_W-1:0] hl;
		logic [DATA_W-1:0] hh;
		logic              is_mul;
		logic              chk;
		logic              neg;
		logic              vs;
		logic [WBITS-1:0]  w;
	} mulpp_t;

	typedef struct packed {
		logic [DATA_W-1:0] hi;
		logic [DATA_W-1:0] lo;
		logic              is_mul;
		logic              chk;
		logic              neg;
		logic              vs;
		logic [WBITS-1:0]  w;
	} mulsum_t;

	function automatic logic [WBITS-1:0] clamp_width(input logic [WBITS-1:0] w);
		logic [WBITS-1:0] r;
		if (w == '0) r = WBITS'(1);
		else if (w > WBITS'(MAX_WIDTH)) r = WBITS'(MAX_WIDTH);
		else r = w;
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] width_mask(input logic [WBITS-1:0] w);
		return ~({DATA_W{1'b1}} << w);
	endfunction

	function automatic logic top_bit(input logic [DATA_W-1:0] x, input logic [WBITS-1:0] w);
		logic [WBITS-2:0] idx;
		idx = (WBITS-1)'(w - WBITS'(1));
		return x[idx];
	endfunction

endpackage

@@ hdl/checked_integer_alu.sv @@
// Overflow-checked integer ALU with trap: top level.
//
// The op channel takes one operation per beat: opcode, two 64-bit operands
// and the widths and signedness of the operand, shift count and cast target.
// The res channel returns one beat per operation, in order: the result in
// its low bits (upper bits zero) and a trap flag; a trapped result is zero.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low.
// An accepted op beat reaches its res beat through one decode stage, 64
// divider stages of one quotient bit each, and the output register.
// Every operation goes through the same pipeline, so a new beat is taken in
// every cycle that op_stall is low and throughput is one operation per cycle.
// When res_stall holds a valid result, the whole pipeline holds and op_stall
// rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits; the pipeline is empty afterwards.
module checked_integer_alu (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            op_valid,
	output logic            op_stall,
	input  cia_pkg::req_t   op,
	output logic            res_valid,
	input  logic            res_stall,
	output cia_pkg::rsp_t   res
);
	import cia_pkg::*;

	logic [LAST_STAGE:1] vld_s;
	logic                adv;

	dec_t    dec_d;
	dec_t    dec_s1;
	side_t   side_d;
	mulpp_t  mul_d;
	mulpp_t  mul_s2;
	mulsum_t mul_s3;
	side_t   side_s [2:LAST_SIDE];
	side_t   side_mul;
	logic [DATA_W-1:0] quo;
	logic [DATA_W-1:0] rmd;
	rsp_t    res_d;
	rsp_t    res_s66;

	assign adv      = ~vld_s[LAST_STAGE] | ~res_stall;
	assign op_stall = ~adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAST_STAGE-1:1], op_valid};
		end
	end

	// Decode: clamp widths, mask operands, form magnitudes for signed types.
	always_comb begin
		logic [WBITS-1:0]  cw;
		logic [DATA_W-1:0] cmask;
		logic [DATA_W-1:0] c;
		dec_d.op = op.operation;
		dec_d.w  = clamp_width(op.value_bits);
		dec_d.tw = clamp_width(op.cast_bits);
		cw       = clamp_width(op.count_bits);
		dec_d.vs = op.value_signed;
		dec_d.ts = op.target_signed;
		dec_d.m  = width_mask(dec_d.w);
		dec_d.a  = op.lhs & dec_d.m;
		dec_d.b  = op.rhs & dec_d.m;
		dec_d.na = top_bit(dec_d.a, dec_d.w);
		dec_d.nb = top_bit(dec_d.b, dec_d.w);
		dec_d.ma = (dec_d.vs && dec_d.na) ? (DATA_W'(0) - (dec_d.a | ~dec_d.m)) : dec_d.a;
		dec_d.mb = (dec_d.vs && dec_d.nb) ? (DATA_W'(0) - (dec_d.b | ~dec_d.m)) : dec_d.b;
		cmask         = width_mask(cw);
		c             = op.rhs & cmask;
		dec_d.cnt     = c;
		dec_d.cnt_neg = op.count_signed && top_bit(c, cw);
	end

	always_ff @(posedge clk) begin
		if (adv) dec_s1 <= dec_d;
	end

	// Everything but the multiply and divide finishes here.
	always_comb begin
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] m;
		logic [DATA_W-1:0] sum;
		logic [DATA_W-1:0] dif;
		logic [DATA_W-1:0] nega;
		logic [DATA_W-1:0] sa;
		logic [DATA_W-1:0] smin;
		logic [DATA_W-1:0] v;
		logic [DATA_W-1:0] tm;
		logic [5:0]        amt;
		logic              sh_trap;
		logic [DATA_W-1:0] r;
		logic              t;
		a    = dec_s1.a;
		b    = dec_s1.b;
		m    = dec_s1.m;
		sum  = (a + b) & m;
		dif  = (a - b) & m;
		nega = (DATA_W'(0) - a) & m;
		sa   = dec_s1.na ? (a | ~m) : a;
		smin = DATA_W'(1) << (dec_s1.w - WBITS'(1));
		v    = dec_s1.vs ? sa : a;
		tm   = width_mask(dec_s1.tw);
		amt  = dec_s1.cnt[5:0];
		sh_trap = dec_s1.cnt_neg || (dec_s1.cnt >= DATA_W'(dec_s1.w));
		r = '0;
		t = 1'b0;
		side_d.is_div   = 1'b0;
		side_d.rem_op   = 1'b0;
		side_d.div_trap = (b == '0) || (dec_s1.vs && a == smin && b == m);
		side_d.qneg     = dec_s1.vs && (dec_s1.na != dec_s1.nb);
		side_d.rneg     = dec_s1.vs && dec_s1.na;
		side_d.m        = m;
		mul_d.is_mul    = 1'b0;
		mul_d.chk       = 1'b0;
		case (opcode_t'(dec_s1.op))
			OP_ADDC: begin
				r = sum;
				t = dec_s1.vs ? top_bit((a ^ sum) & (b ^ sum), dec_s1.w) : (sum < a);
			end
			OP_SUBC: begin
				r = dif;
				t = dec_s1.vs ? top_bit((a ^ b) & (a ^ dif), dec_s1.w) : (b > a);
			end
			OP_MULC: begin
				mul_d.is_mul = 1'b1;
				mul_d.chk    = 1'b1;
			end
			OP_MULW: mul_d.is_mul = 1'b1;
			OP_DIVC: side_d.is_div = 1'b1;
			OP_REMC: begin
				side_d.is_div = 1'b1;
				side_d.rem_op = 1'b1;
			end
			OP_ADDW: r = sum;
			OP_SUBW: r = dif;
			OP_AND:  r = a & b;
			OP_OR:   r = a | b;
			OP_XOR:  r = a ^ b;
			OP_SHL: begin
				t = sh_trap;
				r = (a << amt) & m;
			end
			OP_LSHR: begin
				t = sh_trap;
				r = a >> amt;
			end
			OP_ASHR: begin
				t = sh_trap;
				r = DATA_W'($signed(sa) >>> amt) & m;
			end
			OP_NEGC: begin
				t = dec_s1.vs ? (a == smin) : (a != '0);
				r = nega;
			end
			OP_NEGW: r = nega;
			OP_NOT:  r = ~a & m;
			OP_CASTC: begin
				if (dec_s1.vs && dec_s1.na) begin
					t = !dec_s1.ts ||
						((DATA_W'(0) - v) > (DATA_W'(1) << (dec_s1.tw - WBITS'(1))));
				end else begin
					t = v > (dec_s1.ts ? (tm >> 1) : tm);
				end
				r = v & tm;
			end
			OP_TRUNC: r = v & tm;
			default: t = 1'b1;
		endcase
		side_d.trap   = t;
		side_d.result = t ? '0 : r;
		mul_d.ll  = DATA_W'(dec_s1.ma[31:0])  * DATA_W'(dec_s1.mb[31:0]);
		mul_d.lh  = DATA_W'(dec_s1.ma[31:0])  * DATA_W'(dec_s1.mb[63:32]);
		mul_d.hl  = DATA_W'(dec_s1.ma[63:32]) * DATA_W'(dec_s1.mb[31:0]);
		mul_d.hh  = DATA_W'(dec_s1.ma[63:32]) * DATA_W'(dec_s1.mb[63:32]);
		mul_d.neg = side_d.qneg;
		mul_d.vs  = dec_s1.vs;
		mul_d.w   = dec_s1.w;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[2] <= side_d;
			mul_s2    <= mul_d;
		end
	end

	// Sum the partial products into the 128-bit magnitude product.
	always_ff @(posedge clk) begin
		logic [2*DATA_W-1:0] full;
		if (adv) begin
			full = {64'd0, mul_s2.ll} + {32'd0, mul_s2.lh, 32'd0} +
				{32'd0, mul_s2.hl, 32'd0} + {mul_s2.hh, 64'd0};
			mul_s3.hi     <= full[2*DATA_W-1:DATA_W];
			mul_s3.lo     <= full[DATA_W-1:0];
			mul_s3.is_mul <= mul_s2.is_mul;
			mul_s3.chk    <= mul_s2.chk;
			mul_s3.neg    <= mul_s2.neg;
			mul_s3.vs     <= mul_s2.vs;
			mul_s3.w      <= mul_s2.w;
			side_s[3]     <= side_s[2];
		end
	end

	// Apply the product sign and check the range.
	always_comb begin
		logic [DATA_W-1:0] lim;
		logic [DATA_W-1:0] sl;
		logic              t;
		lim = (DATA_W'(1) << (mul_s3.w - WBITS'(1))) - (mul_s3.neg ? DATA_W'(0) : DATA_W'(1));
		sl  = mul_s3.neg ? (DATA_W'(0) - mul_s3.lo) : mul_s3.lo;
		t   = mul_s3.chk && ((mul_s3.hi != '0) ||
			(mul_s3.vs ? (mul_s3.lo > lim) : (mul_s3.lo > side_s[3].m)));
		side_mul = side_s[3];
		if (mul_s3.is_mul) begin
			side_mul.trap   = t;
			side_mul.result = t ? '0 : (sl & side_s[3].m);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) side_s[4] <= side_mul;
	end

	for (genvar k = 5; k <= LAST_SIDE; k++) begin : g_delay
		always_ff @(posedge clk) begin
			if (adv) side_s[k] <= side_s[k-1];
		end
	end

	cia_divider u_div (
		.clk       (clk),
		.en        (adv),
		.dividend  (dec_s1.ma),
		.divisor   (dec_s1.mb),
		.quotient  (quo),
		.remainder (rmd)
	);

	always_comb begin
		logic [DATA_W-1:0] val;
		res_d.result = side_s[LAST_SIDE].result;
		res_d.trap   = side_s[LAST_SIDE].trap;
		if (side_s[LAST_SIDE].rem_op) begin
			val = side_s[LAST_SIDE].rneg ? (DATA_W'(0) - rmd) : rmd;
		end else begin
			val = side_s[LAST_SIDE].qneg ? (DATA_W'(0) - quo) : quo;
		end
		if (side_s[LAST_SIDE].is_div) begin
			res_d.trap   = side_s[LAST_SIDE].div_trap;
			res_d.result = side_s[LAST_SIDE].div_trap ? '0 : (val & side_s[LAST_SIDE].m);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_s66 <= res_d;
	end

	assign res_valid = vld_s[LAST_STAGE];
	assign res       = res_s66;

endmodule

@@ hdl/cia_divider.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
module cia_divider (
	input  logic                       clk,
	input  logic                       en,
	input  logic [cia_pkg::DATA_W-1:0] dividend,
	input  logic [cia_pkg::DATA_W-1:0] divisor,
	output logic [cia_pkg::DATA_W-1:0] quotient,
	output logic [cia_pkg::DATA_W-1:0] remainder
);
	import cia_pkg::*;

	logic [DATA_W-1:0] rem_s [1:DIV_STAGES];
	logic [DATA_W-1:0] dvd_s [1:DIV_STAGES];
	logic [DATA_W-1:0] dvs_s [1:DIV_STAGES];

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
		logic [DATA_W-1:0] rem_in;
		logic [DATA_W-1:0] dvd_in;
		logic [DATA_W-1:0] dvs_in;
		logic [DATA_W:0]   part;
		logic [DATA_W:0]   diff;

		if (k == 1) begin : g_first
			assign rem_in = '0;
			assign dvd_in = dividend;
			assign dvs_in = divisor;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign dvd_in = dvd_s[k-1];
			assign dvs_in = dvs_s[k-1];
		end

		always_comb begin
			part = {rem_in, dvd_in[DATA_W-1]};
			diff = part - {1'b0, dvs_in};
		end

		// The dividend shifts out at the top while quotient bits enter at the bottom.
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= diff[DATA_W] ? part[DATA_W-1:0] : diff[DATA_W-1:0];
				dvd_s[k] <= {dvd_in[DATA_W-2:0], ~diff[DATA_W]};
				dvs_s[k] <= dvs_in;
			end
		end
	end

	assign quotient  = dvd_s[DIV_STAGES];
	assign remainder = rem_s[DIV_STAGES];

endmodule

@@ hdl/cia_checker.sv @@
// Port checker for the checked integer ALU and its bind.
module cia_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          op_valid,
	input logic          op_stall,
	input cia_pkg::req_t op,
	input logic          res_valid,
	input logic          res_stall,
	input cia_pkg::rsp_t res
);
	import cia_pkg::*;

	// A trapped beat always carries a zero result.
	a_trap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.trap |-> res.result == '0)
		else $error("trapped result is not zero");

	// The input side only holds off while a result is stuck at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		op_stall |-> res_valid && res_stall)
		else $error("op_stall without a stalled result");

	// An unstalled pipeline with no output pending keeps accepting.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !op_stall)
		else $error("op_stall raised with an empty output");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result beat changed");

endmodule

bind checked_integer_alu cia_checker u_cia_checker (.*);
